>>> rtl/core/assert_macros.svh
// Assertion macros shared by the page-buffer directory RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CHBD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/chbd_pkg.sv
// Types and constants shared by the page-buffer directory modules.
package chbd_pkg;

   localparam int CMD_W       = 2;
   localparam int VOL_W       = 16;
   localparam int PAGE_W      = 31;
   localparam int KEY_W       = VOL_W + PAGE_W;
   localparam int BIDX_W      = 6;
   localparam int STATUS_W    = 2;
   localparam int BKT_CFG_W   = 8;
   localparam int BUF_CFG_W   = 7;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CFG_POOLS   = 2;
   localparam int SUM_W       = 32;
   localparam int MOD_STEP_BITS = 8;
   localparam int MOD_STEPS   = SUM_W / MOD_STEP_BITS;
   localparam int BKT_WIDE_W  = 14;
   localparam int IDX_WIDE_W  = 13;

   localparam logic [BKT_CFG_W-1:0] BUCKETS_RESET = 8'd128;
   localparam logic [BUF_CFG_W-1:0] BUFFERS_RESET = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_BUCKETS_ZERO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUCKETS_ONE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFERS_ZERO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFERS_ONE  = 2'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type             command;
      logic                pool_select;
      logic [VOL_W-1:0]    vol_no;
      logic [PAGE_W-1:0]   page_no;
      logic [BIDX_W-1:0]   buffer_index;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [BIDX_W-1:0]   found_index;
   } rsp_type;

   // Effective (already clamped) limits of one pool.
   typedef struct packed {
      logic [BKT_CFG_W-1:0] buckets;
      logic [BUF_CFG_W-1:0] buffers;
   } pool_cfg_type;

endpackage

>>> rtl/core/chbd_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module chbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/chbd_mod_unit.sv
// Iterative remainder unit: 32-bit sum modulo an 8-bit bucket count.
`include "assert_macros.svh"

module chbd_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [chbd_pkg::SUM_W-1:0]     dividend,
   input  logic [chbd_pkg::BKT_CFG_W-1:0] divisor,
   output logic                           done,
   output logic [chbd_pkg::BKT_CFG_W-1:0] remainder
);

   localparam int SW  = chbd_pkg::SUM_W;
   localparam int DW  = chbd_pkg::BKT_CFG_W;
   localparam int SB  = chbd_pkg::MOD_STEP_BITS;
   localparam int CW  = $clog2(chbd_pkg::MOD_STEPS);
   localparam logic [CW-1:0] CNT_LAST = CW'(chbd_pkg::MOD_STEPS - 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] dividend_ff, dividend_in;
   logic [DW-1:0] divisor_ff, divisor_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] rem_step;

   // One restoring step per dividend bit, a byte of bits per cycle.
   always_comb begin
      logic [DW:0]   trial;
      logic [DW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < SB; i++) begin
         trial = {r, dividend_ff[SW-1-i]};
         if (trial >= {1'b0, divisor_ff}) begin
            trial = trial - {1'b0, divisor_ff};
         end
         r = trial[DW-1:0];
      end
      rem_step = r;
   end

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      cnt_in      = cnt_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      if (start) begin
         busy_in     = 1'b1;
         cnt_in      = '0;
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         rem_in      = rem_step;
         dividend_in = dividend_ff << SB;
         cnt_in      = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `CHBD_ASSERT(a_rem_below_divisor, clock, reset, done_ff |-> (rem_ff < divisor_ff), "remainder not below bucket count")
   `CHBD_ASSERT_NEVER(a_start_while_busy, clock, reset, start && busy_ff, "remainder unit restarted while busy")

endmodule

>>> rtl/core/chbd_ctrl.sv
// Directory sequencer: hashing, chain walk and read-modify-write of both memories.
`include "assert_macros.svh"

module chbd_ctrl #(
   parameter int MAX_BUFFERS = 64,
   parameter int MAX_BUCKETS = 128,
   parameter int NUM_POOLS   = 2,
   localparam int IW     = $clog2(MAX_BUFFERS),
   localparam int HAW    = $clog2(NUM_POOLS * MAX_BUCKETS),
   localparam int SAW    = $clog2(NUM_POOLS * MAX_BUFFERS),
   localparam int HEAD_W = IW + 1,
   localparam int SLOT_W = chbd_pkg::KEY_W + 1 + IW
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  chbd_pkg::req_type       req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output chbd_pkg::rsp_type       rsp_payload,
   input  chbd_pkg::pool_cfg_type [chbd_pkg::CFG_POOLS-1:0] pool_cfg,
   output logic                           mod_start,
   output logic [chbd_pkg::SUM_W-1:0]     mod_dividend,
   output logic [chbd_pkg::BKT_CFG_W-1:0] mod_divisor,
   input  logic                           mod_done,
   input  logic [chbd_pkg::BKT_CFG_W-1:0] mod_remainder,
   output logic                    head_we,
   output logic [HAW-1:0]          head_waddr,
   output logic [HEAD_W-1:0]       head_wdata,
   output logic                    head_re,
   output logic [HAW-1:0]          head_raddr,
   input  logic [HEAD_W-1:0]       head_rdata,
   output logic                    slot_we,
   output logic [SAW-1:0]          slot_waddr,
   output logic [SLOT_W-1:0]       slot_wdata,
   output logic                    slot_re,
   output logic [SAW-1:0]          slot_raddr,
   input  logic [SLOT_W-1:0]       slot_rdata
);

   localparam int KW  = chbd_pkg::KEY_W;
   localparam int SW  = chbd_pkg::SUM_W;
   localparam int XW  = chbd_pkg::IDX_WIDE_W;
   localparam int BW  = chbd_pkg::BIDX_W;
   localparam logic [HAW-1:0] HEAD_LAST = HAW'(NUM_POOLS * MAX_BUCKETS - 1);
   localparam logic [IW-1:0]  STEP_LAST = IW'(MAX_BUFFERS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HEAD_CHK,
      ST_SLOT_CHK,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   chbd_pkg::req_type req_ff, req_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic [HAW-1:0]    clr_addr_ff, clr_addr_in;
   logic [HAW-1:0]    head_addr_ff, head_addr_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     prev_ff, prev_in;
   logic [KW-1:0]     prev_key_ff, prev_key_in;
   logic              has_prev_ff, has_prev_in;
   logic [IW-1:0]     steps_ff, steps_in;
   chbd_pkg::rsp_type result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   chbd_pkg::rsp_type rsp_ff, rsp_in;

   logic              acc_pool;
   logic              acc_bad;
   logic              pool_eff;
   logic [KW-1:0]     key;
   logic [HAW-1:0]    head_base;
   logic [HAW-1:0]    head_addr_calc;
   logic [SAW-1:0]    slot_base;
   logic [XW-1:0]     bidx_wide;
   logic [IW-1:0]     bidx_idx;
   logic [XW-1:0]     cur_wide;
   logic [KW-1:0]     slot_key;
   logic              slot_match;

   // A pool number past the configured pool count folds onto the last pool.
   assign acc_pool = (NUM_POOLS > 1) ? req_payload.pool_select : 1'b0;
   assign pool_eff = (NUM_POOLS > 1) ? req_ff.pool_select : 1'b0;
   assign acc_bad  = ({1'b0, req_payload.buffer_index} >= pool_cfg[acc_pool].buffers);

   assign mod_dividend = SW'(req_payload.vol_no) + SW'(req_payload.page_no);
   assign mod_divisor  = pool_cfg[acc_pool].buckets;

   assign key            = {req_ff.vol_no, req_ff.page_no};
   assign head_base      = pool_eff ? HAW'(MAX_BUCKETS) : '0;
   assign head_addr_calc = head_base + HAW'(mod_remainder);
   assign slot_base      = pool_eff ? SAW'(MAX_BUFFERS) : '0;
   assign bidx_wide      = XW'(req_ff.buffer_index);
   assign bidx_idx       = bidx_wide[IW-1:0];
   assign cur_wide       = XW'(cur_ff);
   assign slot_key       = slot_rdata[SLOT_W-1 -: KW];
   assign slot_match     = (slot_key == key);

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      clr_rsp_in   = clr_rsp_ff;
      clr_addr_in  = clr_addr_ff;
      head_addr_in = head_addr_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_key_in  = prev_key_ff;
      has_prev_in  = has_prev_ff;
      steps_in     = steps_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mod_start    = 1'b0;
      head_we      = 1'b0;
      head_waddr   = head_addr_ff;
      head_wdata   = '0;
      head_re      = 1'b0;
      head_raddr   = head_addr_calc;
      slot_we      = 1'b0;
      slot_waddr   = '0;
      slot_wdata   = '0;
      slot_re      = 1'b0;
      slot_raddr   = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep every bucket head to empty, one entry per cycle.
            head_we    = 1'b1;
            head_waddr = clr_addr_ff;
            if (clr_addr_ff == HEAD_LAST) begin
               clr_addr_in = '0;
               clr_rsp_in  = 1'b0;
               if (clr_rsp_ff) begin
                  result_in.status      = chbd_pkg::STATUS_OK;
                  result_in.found_index = '0;
                  state_in              = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in                = req_payload;
               result_in.status      = chbd_pkg::STATUS_OK;
               result_in.found_index = '0;
               if (req_payload.command == chbd_pkg::CMD_CLEAR) begin
                  clr_rsp_in  = 1'b1;
                  clr_addr_in = '0;
                  state_in    = ST_CLEAR;
               end else if (req_payload.command == chbd_pkg::CMD_INSERT && acc_bad) begin
                  result_in.status = chbd_pkg::STATUS_BAD_INDEX;
                  state_in         = ST_DONE;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (mod_done) begin
               head_re      = 1'b1;
               head_addr_in = head_addr_calc;
               steps_in     = '0;
               has_prev_in  = 1'b0;
               state_in     = ST_HEAD_CHK;
            end
         end
         ST_HEAD_CHK: begin
            if (req_ff.command == chbd_pkg::CMD_INSERT) begin
               // New entry takes the old head as its successor.
               slot_we    = 1'b1;
               slot_waddr = slot_base + SAW'(bidx_idx);
               slot_wdata = {key, head_rdata};
               head_we    = 1'b1;
               head_wdata = {1'b1, bidx_idx};
               state_in   = ST_DONE;
            end else if (!head_rdata[IW]) begin
               result_in.status = chbd_pkg::STATUS_NOT_FOUND;
               state_in         = ST_DONE;
            end else begin
               slot_re    = 1'b1;
               slot_raddr = slot_base + SAW'(head_rdata[IW-1:0]);
               cur_in     = head_rdata[IW-1:0];
               state_in   = ST_SLOT_CHK;
            end
         end
         ST_SLOT_CHK: begin
            if (slot_match) begin
               if (req_ff.command == chbd_pkg::CMD_DELETE) begin
                  if (has_prev_ff) begin
                     slot_we    = 1'b1;
                     slot_waddr = slot_base + SAW'(prev_ff);
                     slot_wdata = {prev_key_ff, slot_rdata[IW:0]};
                  end else begin
                     head_we    = 1'b1;
                     head_wdata = slot_rdata[IW:0];
                  end
               end else begin
                  result_in.found_index = cur_wide[BW-1:0];
               end
               state_in = ST_DONE;
            end else begin
               prev_in     = cur_ff;
               prev_key_in = slot_key;
               has_prev_in = 1'b1;
               steps_in    = steps_ff + 1'b1;
               // The walk gives up at the end of the chain or after a full
               // pool's worth of slots, which also ends a cyclic chain.
               if (steps_ff == STEP_LAST || !slot_rdata[IW]) begin
                  result_in.status = chbd_pkg::STATUS_NOT_FOUND;
                  state_in         = ST_DONE;
               end else begin
                  slot_re    = 1'b1;
                  slot_raddr = slot_base + SAW'(slot_rdata[IW-1:0]);
                  cur_in     = slot_rdata[IW-1:0];
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_rsp_ff   <= 1'b0;
         clr_addr_ff  <= '0;
         has_prev_ff  <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_rsp_ff   <= clr_rsp_in;
         clr_addr_ff  <= clr_addr_in;
         has_prev_ff  <= has_prev_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      head_addr_ff <= head_addr_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_key_ff  <= prev_key_in;
      result_ff    <= result_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CHBD_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result loaded outside the completion state")
   `CHBD_ASSERT(a_walk_bound, clock, reset, (state_ff == ST_SLOT_CHK) |-> (steps_ff <= STEP_LAST), "chain walk ran past the slot limit")
   `CHBD_ASSERT_NEVER(a_slot_port_clash, clock, reset, slot_we && slot_re && (slot_waddr == slot_raddr), "slot memory read and written at one entry")

endmodule

>>> rtl/core/chained_hash_buffer_directory_top.sv
// Top level of the page-buffer directory: registers, limits and the directory core.
//
// Channel  Dir  Handshake                    Payload
// req      in   req_valid / req_ready        chbd_pkg::req_type
// rsp      out  rsp_valid / rsp_ready        chbd_pkg::rsp_type
// csr      in   csr_write_en, no wait state  csr_index, csr_wdata
//
// One transaction is handled at a time. An insert runs the four-step remainder unit and
// one read of the registered head memory before its writes; lookup and delete also read one
// slot per chain entry compared, and a rejected insert skips the hash and both memories. A
// clear sweeps NUM_POOLS * MAX_BUCKETS bucket heads, one per cycle; the same sweep runs
// after reset with req_ready low. Configuration writes are taken at any time. A result
// waiting on rsp_ready does not keep a new transaction out.
module chained_hash_buffer_directory_top #(
   parameter int MAX_BUFFERS = 64,
   parameter int MAX_BUCKETS = 128,
   parameter int NUM_POOLS   = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  chbd_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output chbd_pkg::rsp_type               rsp_payload,
   input  logic                            csr_write_en,
   input  logic [chbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chbd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW     = $clog2(MAX_BUFFERS);
   localparam int HAW    = $clog2(NUM_POOLS * MAX_BUCKETS);
   localparam int SAW    = $clog2(NUM_POOLS * MAX_BUFFERS);
   localparam int HEAD_W = IW + 1;
   localparam int SLOT_W = chbd_pkg::KEY_W + 1 + IW;
   localparam int KBW    = chbd_pkg::BKT_WIDE_W;
   localparam int KXW    = chbd_pkg::IDX_WIDE_W;
   localparam int DW     = chbd_pkg::BKT_CFG_W;
   localparam int NW     = chbd_pkg::BUF_CFG_W;

   // Bucket count: zero acts as one, and the count never exceeds the table size.
   function automatic logic [DW-1:0] clamp_buckets(input logic [DW-1:0] cfg);
      logic [KBW-1:0] w;
      w = KBW'(cfg);
      if (w == '0) begin
         w = KBW'(1);
      end
      if (w > KBW'(MAX_BUCKETS)) begin
         w = KBW'(MAX_BUCKETS);
      end
      return w[DW-1:0];
   endfunction

   // Buffer count: capped at the slot storage of one pool; zero rejects every insert.
   function automatic logic [NW-1:0] clamp_buffers(input logic [NW-1:0] cfg);
      logic [KXW-1:0] w;
      w = KXW'(cfg);
      if (w > KXW'(MAX_BUFFERS)) begin
         w = KXW'(MAX_BUFFERS);
      end
      return w[NW-1:0];
   endfunction

   logic [DW-1:0] bkt0_ff, bkt0_in;
   logic [DW-1:0] bkt1_ff, bkt1_in;
   logic [NW-1:0] buf0_ff, buf0_in;
   logic [NW-1:0] buf1_ff, buf1_in;

   chbd_pkg::pool_cfg_type [chbd_pkg::CFG_POOLS-1:0] pool_cfg;

   logic                    mod_start;
   logic [chbd_pkg::SUM_W-1:0] mod_dividend;
   logic [DW-1:0]           mod_divisor;
   logic                    mod_done;
   logic [DW-1:0]           mod_remainder;

   logic                    head_we;
   logic [HAW-1:0]          head_waddr;
   logic [HEAD_W-1:0]       head_wdata;
   logic                    head_re;
   logic [HAW-1:0]          head_raddr;
   logic [HEAD_W-1:0]       head_rdata;
   logic                    slot_we;
   logic [SAW-1:0]          slot_waddr;
   logic [SLOT_W-1:0]       slot_wdata;
   logic                    slot_re;
   logic [SAW-1:0]          slot_raddr;
   logic [SLOT_W-1:0]       slot_rdata;

   // Configuration registers; an index outside the list changes nothing.
   always_comb begin
      bkt0_in = bkt0_ff;
      bkt1_in = bkt1_ff;
      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            chbd_pkg::CSR_BUCKETS_ZERO: bkt0_in = csr_wdata;
            chbd_pkg::CSR_BUCKETS_ONE:  bkt1_in = csr_wdata;
            chbd_pkg::CSR_BUFFERS_ZERO: buf0_in = csr_wdata[NW-1:0];
            chbd_pkg::CSR_BUFFERS_ONE:  buf1_in = csr_wdata[NW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bkt0_ff <= chbd_pkg::BUCKETS_RESET;
         bkt1_ff <= chbd_pkg::BUCKETS_RESET;
         buf0_ff <= chbd_pkg::BUFFERS_RESET;
         buf1_ff <= chbd_pkg::BUFFERS_RESET;
      end else begin
         bkt0_ff <= bkt0_in;
         bkt1_ff <= bkt1_in;
         buf0_ff <= buf0_in;
         buf1_ff <= buf1_in;
      end
   end

   assign pool_cfg[0].buckets = clamp_buckets(bkt0_ff);
   assign pool_cfg[0].buffers = clamp_buffers(buf0_ff);
   assign pool_cfg[1].buckets = clamp_buckets(bkt1_ff);
   assign pool_cfg[1].buffers = clamp_buffers(buf1_ff);

   // The sequencer owns both memories and runs one transaction at a time, so a
   // write always lands before the next transaction's first read of that entry.
   chbd_ctrl #(
      .MAX_BUFFERS (MAX_BUFFERS),
      .MAX_BUCKETS (MAX_BUCKETS),
      .NUM_POOLS   (NUM_POOLS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .pool_cfg      (pool_cfg),
      .mod_start     (mod_start),
      .mod_dividend  (mod_dividend),
      .mod_divisor   (mod_divisor),
      .mod_done      (mod_done),
      .mod_remainder (mod_remainder),
      .head_we       (head_we),
      .head_waddr    (head_waddr),
      .head_wdata    (head_wdata),
      .head_re       (head_re),
      .head_raddr    (head_raddr),
      .head_rdata    (head_rdata),
      .slot_we       (slot_we),
      .slot_waddr    (slot_waddr),
      .slot_wdata    (slot_wdata),
      .slot_re       (slot_re),
      .slot_raddr    (slot_raddr),
      .slot_rdata    (slot_rdata)
   );

   // Bucket index is (vol_no + page_no) mod the pool's bucket count.
   chbd_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_remainder)
   );

   // Bucket heads: {valid, slot index} per pool and bucket.
   chbd_ram #(
      .WIDTH (HEAD_W),
      .DEPTH (NUM_POOLS * MAX_BUCKETS)
   ) u_head_ram (
      .clock (clock),
      .we    (head_we),
      .waddr (head_waddr),
      .wdata (head_wdata),
      .re    (head_re),
      .raddr (head_raddr),
      .rdata (head_rdata)
   );

   // Slots: {page key, next valid, next slot index} per pool and buffer.
   chbd_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (NUM_POOLS * MAX_BUFFERS)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

endmodule

>>> dv/directory_checker.sv
// Checker for the page-buffer directory: predicts every response and compares it.
`timescale 1ns / 100ps

module directory_checker
   import chbd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count
);

   localparam int DIR_BUCKETS = 128;
   localparam int DIR_BUFFERS = 64;

   logic [BKT_CFG_W-1:0] bucket_cfg [CFG_POOLS];
   logic [BUF_CFG_W-1:0] buffer_cfg [CFG_POOLS];

   int                   head_slot  [CFG_POOLS][DIR_BUCKETS];
   bit                   head_live  [CFG_POOLS][DIR_BUCKETS];
   int                   next_slot  [CFG_POOLS][DIR_BUFFERS];
   bit                   next_live  [CFG_POOLS][DIR_BUFFERS];
   logic [KEY_W-1:0]     stored_key [CFG_POOLS][DIR_BUFFERS];

   rsp_type              outcome_queue [$];

   // Walks one chain for a key. A walk gives up after DIR_BUFFERS slots, which
   // keeps cyclic chains from running forever.
   function automatic bit find_slot(input int pool, input int bucket,
                                    input logic [KEY_W-1:0] key,
                                    output int slot, output int prev,
                                    output bit has_prev);
      bit live;
      int cur;
      live     = head_live[pool][bucket];
      cur      = head_slot[pool][bucket];
      slot     = 0;
      prev     = 0;
      has_prev = 1'b0;
      for (int step = 0; step < DIR_BUFFERS; step++) begin
         if (!live) return 1'b0;
         if (stored_key[pool][cur] == key) begin
            slot = cur;
            return 1'b1;
         end
         prev     = cur;
         has_prev = 1'b1;
         live     = next_live[pool][cur];
         cur      = next_slot[pool][cur];
      end
      return 1'b0;
   endfunction

   // Applies one request to the shadow directory and returns its response.
   function automatic rsp_type predict_outcome(input req_type item);
      rsp_type          outcome;
      int               pool;
      int               nbkt;
      int               nbuf;
      int               bucket;
      int               slot;
      int               prev;
      bit               has_prev;
      logic [31:0]      sum;
      logic [KEY_W-1:0] key;
      outcome.status      = STATUS_OK;
      outcome.found_index = '0;
      pool = int'(item.pool_select);
      nbkt = int'(bucket_cfg[pool]);
      if (nbkt == 0) nbkt = 1;
      if (nbkt > DIR_BUCKETS) nbkt = DIR_BUCKETS;
      nbuf = int'(buffer_cfg[pool]);
      if (nbuf > DIR_BUFFERS) nbuf = DIR_BUFFERS;
      key    = {item.vol_no, item.page_no};
      sum    = 32'(item.vol_no) + 32'(item.page_no);
      bucket = int'(sum % 32'(nbkt));
      case (item.command)
         CMD_LOOKUP: begin
            if (find_slot(pool, bucket, key, slot, prev, has_prev))
               outcome.found_index = BIDX_W'(slot);
            else
               outcome.status = STATUS_NOT_FOUND;
         end
         CMD_INSERT: begin
            if (int'(item.buffer_index) >= nbuf) begin
               outcome.status = STATUS_BAD_INDEX;
            end else begin
               slot = int'(item.buffer_index);
               stored_key[pool][slot] = key;
               next_slot[pool][slot]  = head_slot[pool][bucket];
               next_live[pool][slot]  = head_live[pool][bucket];
               head_slot[pool][bucket] = slot;
               head_live[pool][bucket] = 1'b1;
            end
         end
         CMD_DELETE: begin
            if (!find_slot(pool, bucket, key, slot, prev, has_prev)) begin
               outcome.status = STATUS_NOT_FOUND;
            end else if (!has_prev) begin
               head_slot[pool][bucket] = next_slot[pool][slot];
               head_live[pool][bucket] = next_live[pool][slot];
            end else begin
               next_slot[pool][prev] = next_slot[pool][slot];
               next_live[pool][prev] = next_live[pool][slot];
            end
         end
         default: begin
            // Clear drops every head of every pool, not only the configured ones.
            foreach (head_live[p, b]) head_live[p][b] = 1'b0;
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bucket_cfg = '{default: BUCKETS_RESET};
         buffer_cfg = '{default: BUFFERS_RESET};
         foreach (head_live[p, b]) begin
            head_live[p][b] = 1'b0;
            head_slot[p][b] = 0;
         end
         foreach (next_live[p, s]) begin
            next_live[p][s]  = 1'b0;
            next_slot[p][s]  = 0;
            stored_key[p][s] = '0;
         end
         outcome_queue.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_BUCKETS_ZERO: bucket_cfg[0] = csr_wdata[BKT_CFG_W-1:0];
               CSR_BUCKETS_ONE:  bucket_cfg[1] = csr_wdata[BKT_CFG_W-1:0];
               CSR_BUFFERS_ZERO: buffer_cfg[0] = csr_wdata[BUF_CFG_W-1:0];
               default:          buffer_cfg[1] = csr_wdata[BUF_CFG_W-1:0];
            endcase
         end
         // A response at this edge belongs to an older transaction than a request
         // taken at the same edge, so it is checked first.
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               $display("%0t: response with no transaction outstanding: status %0d index %0d",
                        $time, rsp_payload.status, rsp_payload.found_index);
               fail_count++;
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_payload.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_payload.status);
                  fail_count++;
               end
               if (rsp_payload.found_index !== want.found_index) begin
                  $display("%0t: found_index mismatch: expected %0d, actual %0d",
                           $time, want.found_index, rsp_payload.found_index);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            outcome_queue.push_back(predict_outcome(req_payload));
         pending_count = outcome_queue.size();
      end
   end

endmodule

>>> dv/testbench.sv
// Top of the page-buffer directory testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import chbd_pkg::*;

   // Longest quiet stretch a correct run can show is a clear sweep behind a long
   // response stall; QUIET_LIMIT allows for that many times over.
   localparam int QUIET_LIMIT = 5000;
   localparam int KEY_SLOTS   = 16;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int                    check_failures;
   int                    outcomes_due;
   int                    send_idle_pct;
   int                    recv_idle_pct;
   int                    quiet_cycles;

   // Shadow of the buffer counts, used only to keep most inserts in range.
   int                    slot_limit [CFG_POOLS];

   // A small working set of page keys, so that lookups and deletes mostly hit.
   logic [VOL_W-1:0]      vol_set  [KEY_SLOTS];
   logic [PAGE_W-1:0]     page_set [KEY_SLOTS];

   chained_hash_buffer_directory_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   directory_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (check_failures),
      .pending_count (outcomes_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The response side stalls on its own schedule, one decision per cycle.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any cycle with a transaction on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic req_type make_req(input cmd_type cmd, input logic pool,
                                        input logic [VOL_W-1:0] vol,
                                        input logic [PAGE_W-1:0] page,
                                        input logic [BIDX_W-1:0] idx);
      req_type item;
      item.command      = cmd;
      item.pool_select  = pool;
      item.vol_no       = vol;
      item.page_no      = page;
      item.buffer_index = idx;
      return item;
   endfunction

   // Offers one request and holds it until the directory takes it. Entered and
   // left at a falling edge; valid goes low only after acceptance.
   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_payload = item;
      req_valid   = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = data;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Holds the request side until every outstanding transaction has answered.
   task automatic wait_drained();
      while (outcomes_due != 0) @(negedge clock);
   endtask

   task automatic refresh_keys();
      foreach (vol_set[k]) begin
         vol_set[k]  = VOL_W'($urandom);
         page_set[k] = PAGE_W'($urandom);
      end
   endtask

   // Reprograms all four registers while idle, then runs a batch of mostly
   // well-formed traffic against the small key set. Buffer counts are written
   // as 8-bit values cut to 7 bits; 7-bit values above 64 exercise the clamp.
   task automatic run_random(input logic [CSR_DATA_W-1:0] bkt0,
                             input logic [CSR_DATA_W-1:0] bkt1,
                             input logic [CSR_DATA_W-1:0] buf0,
                             input logic [CSR_DATA_W-1:0] buf1,
                             input int items);
      int      roll;
      int      k;
      logic    pool;
      cmd_type cmd;
      logic [BIDX_W-1:0]  idx;
      logic [VOL_W-1:0]   vol;
      logic [PAGE_W-1:0]  page;
      wait_drained();
      write_reg(CSR_BUCKETS_ZERO, bkt0);
      write_reg(CSR_BUCKETS_ONE, bkt1);
      write_reg(CSR_BUFFERS_ZERO, buf0);
      write_reg(CSR_BUFFERS_ONE, buf1);
      slot_limit[0] = (int'(buf0[BUF_CFG_W-1:0]) > 64) ? 64 : int'(buf0[BUF_CFG_W-1:0]);
      slot_limit[1] = (int'(buf1[BUF_CFG_W-1:0]) > 64) ? 64 : int'(buf1[BUF_CFG_W-1:0]);
      refresh_keys();
      repeat (items) begin
         roll = $urandom_range(99);
         pool = 1'($urandom_range(1));
         k    = $urandom_range(KEY_SLOTS - 1);
         vol  = vol_set[k];
         page = page_set[k];
         if (roll < 40)
            cmd = CMD_INSERT;
         else if (roll < 70)
            cmd = CMD_LOOKUP;
         else if (roll < 90)
            cmd = CMD_DELETE;
         else if (roll < 98) begin
            // Noise: a lookup, insert or delete with a key outside the working set.
            cmd  = cmd_type'($urandom_range(2));
            vol  = VOL_W'($urandom);
            page = PAGE_W'($urandom);
         end else
            cmd = CMD_CLEAR;
         if ($urandom_range(9) < 8 && slot_limit[pool] > 0)
            idx = BIDX_W'($urandom_range(slot_limit[pool] - 1));
         else
            idx = BIDX_W'($urandom_range(63));
         // Let the working set drift now and then.
         if ($urandom_range(19) == 0) begin
            vol_set[k]  = VOL_W'($urandom);
            page_set[k] = PAGE_W'($urandom);
         end
         send_req(make_req(cmd, pool, vol, page, idx));
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_BUCKETS_ZERO;
      csr_wdata     = '0;
      send_idle_pct = 30;
      recv_idle_pct = 51;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset sizes: 128 buckets, 64 buffers. The keys (0,0), (0,128) and (1,127)
      // all hash to bucket 0, so they build one chain of three.
      send_req(make_req(CMD_CLEAR, 1'b0, '0, '0, '0));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd0, '0));
      send_req(make_req(CMD_INSERT, 1'b0, 16'd0, 31'd0, 6'd0));
      send_req(make_req(CMD_INSERT, 1'b0, 16'd0, 31'd128, 6'd63));
      send_req(make_req(CMD_INSERT, 1'b0, 16'd1, 31'd127, 6'd5));
      // Hit at the tail, then in the middle.
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd0, 6'd17));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd128, '0));
      // Unlink from the middle, then from the head, then miss.
      send_req(make_req(CMD_DELETE, 1'b0, 16'd0, 31'd128, '0));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd128, '0));
      send_req(make_req(CMD_DELETE, 1'b0, 16'd1, 31'd127, '0));
      send_req(make_req(CMD_DELETE, 1'b0, 16'd1, 31'd127, '0));
      // Linking slot 0 again while it heads the chain makes it point to itself;
      // a miss in that bucket must give up after a bounded walk.
      send_req(make_req(CMD_INSERT, 1'b0, 16'd0, 31'd0, 6'd0));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd128, '0));
      // A duplicate key in slot 7 shadows the one in slot 0 until deleted.
      send_req(make_req(CMD_INSERT, 1'b0, 16'd0, 31'd0, 6'd7));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd0, '0));
      send_req(make_req(CMD_DELETE, 1'b0, 16'd0, 31'd0, '0));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd0, '0));
      // Largest key and index in pool one; the pools must stay separate.
      send_req(make_req(CMD_INSERT, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, 6'd63));
      send_req(make_req(CMD_LOOKUP, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, '1));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'hFFFF, 31'h7FFF_FFFF, '0));
      // Clear issued on pool one also empties pool zero.
      send_req(make_req(CMD_CLEAR, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, '1));
      send_req(make_req(CMD_LOOKUP, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, '0));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd0, 31'd0, '0));

      // Degenerate sizes: zero buckets act as one, 255 buckets as 128, zero
      // buffers reject every insert, 127 buffers act as 64.
      wait_drained();
      write_reg(CSR_BUCKETS_ZERO, 8'd0);
      write_reg(CSR_BUCKETS_ONE, 8'd255);
      write_reg(CSR_BUFFERS_ZERO, 8'd0);
      write_reg(CSR_BUFFERS_ONE, 8'd255);
      send_req(make_req(CMD_INSERT, 1'b0, 16'd3, 31'd9, 6'd0));
      send_req(make_req(CMD_LOOKUP, 1'b0, 16'd3, 31'd9, '0));
      send_req(make_req(CMD_INSERT, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, 6'd63));
      send_req(make_req(CMD_LOOKUP, 1'b1, 16'hFFFF, 31'h7FFF_FFFF, '0));

      // Random traffic: small bucket counts make long chains, small buffer
      // counts make rejected inserts.
      run_random(8'd3, 8'd128, 8'd16, 8'd64, 120);
      send_idle_pct = 51;
      recv_idle_pct = 30;
      run_random(8'd1, 8'd7, 8'd64, 8'd5, 120);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(8'd128, 8'd2, 8'd1, 8'd200, 120);
      run_random(8'd5, 8'd1, 8'd40, 8'd33, 120);

      wait_drained();
      // Give a stray extra response time to show up before the verdict.
      repeat (40) @(negedge clock);
      if (check_failures == 0 && outcomes_due == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
